// ===== design/can_segmented_frame_builder_top_assert.svh =====
// Assertion macros for the segmented CAN frame builder.
`ifndef CAN_SEGMENTED_FRAME_BUILDER_TOP_ASSERT_SVH
`define CAN_SEGMENTED_FRAME_BUILDER_TOP_ASSERT_SVH

// Same-cycle implication, off during reset.
`define SFB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame builder assertion failed");

// Next-cycle implication, off during reset.
`define SFB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame builder assertion failed");

`endif

// ===== design/can_sfb_pkg.sv =====
// Package: types and constants of the segmented CAN frame builder.
package can_sfb_pkg;

  localparam int MAX_SEGMENTS = 128;

  localparam logic [2:0]  CAP_IDX    = 3'd6;
  localparam logic [2:0]  CAP_PLAIN  = 3'd7;
  localparam logic [10:0] LIMIT_IDX  = 11'(int'(CAP_IDX) * MAX_SEGMENTS);
  localparam logic [10:0] LIMIT_PLAIN = 11'(int'(CAP_PLAIN) * MAX_SEGMENTS);
  localparam logic [3:0]  HDR_IDX    = 4'd2;
  localparam logic [3:0]  HDR_PLAIN  = 4'd1;
  localparam logic [7:0]  LAST_MARK  = 8'h80;
  localparam int          CHUNK_MAX  = 7;

  localparam int          APB_ADDR_W = 3;
  localparam int          APB_DATA_W = 32;
  localparam logic        REG_EXT_MODE = 1'b0;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [9:0]  message_length;
    logic [15:0] frame_id;
    logic        index_en;
    logic [7:0]  entry_index;
  } item_t;

  typedef struct packed {
    logic [15:0] out_frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_data;
    logic        extended_flag;
    logic        last_frame;
    logic        status;
  } result_t;

endpackage

// ===== design/can_sfb_in_if.sv =====
// Input byte channel of the frame builder.
interface can_sfb_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [9:0]  message_length;
  logic [15:0] frame_id;
  logic        index_en;
  logic [7:0]  entry_index;

  modport source (output valid, payload_byte, message_length, frame_id, index_en,
                  entry_index, input ready);
  modport sink   (input valid, payload_byte, message_length, frame_id, index_en,
                  entry_index, output ready);
endinterface

// ===== design/can_sfb_out_if.sv =====
// Output frame channel of the frame builder.
interface can_sfb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_frame_id;
  logic [3:0]  frame_length;
  logic [63:0] frame_data;
  logic        extended_flag;
  logic        last_frame;
  logic        status;

  modport source (output valid, out_frame_id, frame_length, frame_data, extended_flag,
                  last_frame, status, input ready);
  modport sink   (input valid, out_frame_id, frame_length, frame_data, extended_flag,
                  last_frame, status, output ready);
endinterface

// ===== design/can_segmented_frame_builder_top.sv =====
// Top level of the segmented CAN frame builder: config register, core, output buffer.
// A frame beat is registered in the output register, or in the skid behind a held beat.
// Throughput: one byte beat per cycle while the skid is empty; a full skid closes input.
// A two-entry output buffer (output register plus skid) keeps input open while only the output register is full.
// Reset (synchronous, active high): message state cleared, buffer empty, extended mode 1.
module can_segmented_frame_builder_top (
  input  logic                                  clk,
  input  logic                                  rst,
  can_sfb_in_if.sink                            in_ch,
  can_sfb_out_if.source                         out_ch,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [can_sfb_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [can_sfb_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [can_sfb_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                  pready
);
  import can_sfb_pkg::*;

  `include "can_segmented_frame_builder_top_assert.svh"

  // ---- configuration register ----
  logic ext_mode;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  // only the word select bit decodes; index 1 and up read as zero
  assign prdata = (paddr[2] == REG_EXT_MODE) ? {{(APB_DATA_W-1){1'b0}}, ext_mode}
                                             : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_mode <= 1'b1;
    end else if (cfg_wr && paddr[2] == REG_EXT_MODE) begin
      ext_mode <= pwdata[0];
    end
  end

  // ---- framing core ----
  item_t   item;
  result_t res;
  logic    res_valid;
  logic    in_fire;
  logic    skid_valid;

  assign item.payload_byte   = in_ch.payload_byte;
  assign item.message_length = in_ch.message_length;
  assign item.frame_id       = in_ch.frame_id;
  assign item.index_en       = in_ch.index_en;
  assign item.entry_index    = in_ch.entry_index;

  // input stays open unless both buffer slots hold a frame
  assign in_ch.ready = !skid_valid;
  assign in_fire     = in_ch.valid && in_ch.ready;

  can_sfb_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .item      (item),
    .ext_mode  (ext_mode),
    .res_valid (res_valid),
    .res       (res)
  );

  // ---- output register plus skid ----
  result_t out_reg;
  result_t skid_reg;
  logic    out_valid;
  logic    out_fire;

  assign out_fire = out_valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // input is closed; drain skid into the output register
      if (out_fire) begin
        out_reg    <= skid_reg;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid || out_fire) begin
        out_reg   <= res;
        out_valid <= 1'b1;
      end else begin
        skid_reg   <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.out_frame_id  = out_reg.out_frame_id;
  assign out_ch.frame_length  = out_reg.frame_length;
  assign out_ch.frame_data    = out_reg.frame_data;
  assign out_ch.extended_flag = out_reg.extended_flag;
  assign out_ch.last_frame    = out_reg.last_frame;
  assign out_ch.status        = out_reg.status;

  // ---- assertions ----
  // skid only fills behind a held output beat
  `SFB_ASSERT_IMP(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  // an error beat carries no frame
  `SFB_ASSERT_IMP(a_err_empty, clk, rst, out_valid && out_reg.status,
                  out_reg.frame_length == 4'd0 && !out_reg.last_frame)
  // a frame beat always has at least its header byte
  `SFB_ASSERT_IMP(a_frame_has_hdr, clk, rst, out_valid && !out_reg.status,
                  out_reg.frame_length != 4'd0)
  // a config write lands in the mode register
  `SFB_ASSERT_NXT(a_cfg_write, clk, rst, cfg_wr && paddr[2] == REG_EXT_MODE,
                  ext_mode == $past(pwdata[0]))

endmodule

// ===== design/can_sfb_core.sv =====
// Framing core: message state, chunk register and frame assembly.
module can_sfb_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_fire,
  input  can_sfb_pkg::item_t    item,
  input  logic                  ext_mode,
  output logic                  res_valid,
  output can_sfb_pkg::result_t  res
);
  import can_sfb_pkg::*;

  logic                            in_message, in_message_next;
  logic [9:0]                      bytes_taken, bytes_taken_next;
  logic [6:0]                      segment_number, segment_number_next;
  logic [2:0]                      chunk_fill, chunk_fill_next;
  logic [CHUNK_MAX-1:0][7:0]       chunk_bytes, chunk_bytes_next;
  logic [9:0]                      latched_length, latched_length_next;
  logic [15:0]                     latched_id, latched_id_next;
  logic                            latched_index_mode, latched_index_mode_next;
  logic [7:0]                      latched_index, latched_index_next;
  logic                            dropping, dropping_next;

  always_comb begin
    logic                      first;
    logic [9:0]                len;
    logic                      idm;
    logic [7:0]                idx;
    logic [2:0]                cap;
    logic [10:0]               limit;
    logic [9:0]                b_bytes;
    logic [6:0]                b_seg;
    logic [2:0]                b_fill;
    logic [CHUNK_MAX-1:0][7:0] chunk_n;
    logic [2:0]                fill_n;
    logic [9:0]                bytes_n;
    logic                      last;
    logic [7:0]                header;

    first   = !in_message;
    len     = first ? item.message_length : latched_length;
    idm     = first ? item.index_en : latched_index_mode;
    idx     = first ? item.entry_index : latched_index;
    cap     = idm ? CAP_IDX : CAP_PLAIN;
    limit   = idm ? LIMIT_IDX : LIMIT_PLAIN;
    b_bytes = first ? 10'd0 : bytes_taken;
    b_seg   = first ? 7'd0 : segment_number;
    b_fill  = first ? 3'd0 : chunk_fill;
    chunk_n = first ? '0 : chunk_bytes;
    chunk_n[b_fill] = item.payload_byte;
    fill_n  = b_fill + 3'd1;
    bytes_n = b_bytes + 10'd1;
    last    = bytes_n >= len;
    header  = {last, b_seg};

    in_message_next         = in_message;
    bytes_taken_next        = bytes_taken;
    segment_number_next     = segment_number;
    chunk_fill_next         = chunk_fill;
    chunk_bytes_next        = chunk_bytes;
    latched_length_next     = latched_length;
    latched_id_next         = latched_id;
    latched_index_mode_next = latched_index_mode;
    latched_index_next      = latched_index;
    dropping_next           = dropping;

    res_valid         = 1'b0;
    res               = '0;
    res.out_frame_id  = first ? item.frame_id : latched_id;
    res.extended_flag = ext_mode;

    if (in_fire) begin
      if (first) begin
        latched_length_next     = item.message_length;
        latched_id_next         = item.frame_id;
        latched_index_mode_next = item.index_en;
        latched_index_next      = item.entry_index;
        bytes_taken_next        = '0;
        segment_number_next     = '0;
        chunk_fill_next         = '0;
        chunk_bytes_next        = '0;
        dropping_next           = 1'b0;
      end

      if (first && len == 10'd0) begin
        // empty message: lone header-only frame
        res_valid        = 1'b1;
        res.frame_length = idm ? HDR_IDX : HDR_PLAIN;
        res.frame_data   = {48'd0, (idm ? idx : 8'h00), LAST_MARK};
        res.last_frame   = 1'b1;
      end else if (first && {1'b0, len} > limit) begin
        // too long: one error beat, then swallow the rest
        res_valid        = 1'b1;
        res.status       = 1'b1;
        bytes_taken_next = 10'd1;
        if (len > 10'd1) begin
          in_message_next = 1'b1;
          dropping_next   = 1'b1;
        end
      end else if (!first && dropping) begin
        bytes_taken_next = bytes_taken + 10'd1;
        if (bytes_taken_next >= latched_length) begin
          in_message_next = 1'b0;
          dropping_next   = 1'b0;
        end
      end else begin
        in_message_next = 1'b1;
        if (last || fill_n >= cap) begin
          res_valid        = 1'b1;
          res.last_frame   = last;
          res.frame_length = (idm ? HDR_IDX : HDR_PLAIN) + {1'b0, fill_n};
          res.frame_data   = idm ? {chunk_n[CHUNK_MAX-2:0], idx, header}
                                 : {chunk_n, header};
          chunk_fill_next  = '0;
          chunk_bytes_next = '0;
          if (last) begin
            in_message_next     = 1'b0;
            bytes_taken_next    = '0;
            segment_number_next = '0;
          end else begin
            bytes_taken_next    = bytes_n;
            segment_number_next = b_seg + 7'd1;
          end
        end else begin
          chunk_bytes_next    = chunk_n;
          chunk_fill_next     = fill_n;
          bytes_taken_next    = bytes_n;
          segment_number_next = b_seg;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_message         <= 1'b0;
      bytes_taken        <= '0;
      segment_number     <= '0;
      chunk_fill         <= '0;
      chunk_bytes        <= '0;
      latched_length     <= '0;
      latched_id         <= '0;
      latched_index_mode <= 1'b0;
      latched_index      <= '0;
      dropping           <= 1'b0;
    end else begin
      in_message         <= in_message_next;
      bytes_taken        <= bytes_taken_next;
      segment_number     <= segment_number_next;
      chunk_fill         <= chunk_fill_next;
      chunk_bytes        <= chunk_bytes_next;
      latched_length     <= latched_length_next;
      latched_id         <= latched_id_next;
      latched_index_mode <= latched_index_mode_next;
      latched_index      <= latched_index_next;
      dropping           <= dropping_next;
    end
  end

endmodule

// ===== test/can_segmented_frame_builder_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the segmented CAN frame builder top level.
module can_segmented_frame_builder_top_test;
  import can_sfb_pkg::*;

  // Register map: extended-id mode at index 0, one unimplemented slot at index 1.
  localparam logic [APB_ADDR_W-1:0] ADDR_EXT_MODE = APB_ADDR_W'(4 * REG_EXT_MODE);
  localparam logic [APB_ADDR_W-1:0] ADDR_SPARE    = APB_ADDR_W'(4);

  // Frame capacity as the protocol defines it, kept apart from the package on purpose.
  localparam int PAYLOAD_IDX   = 6;
  localparam int PAYLOAD_PLAIN = 7;
  localparam int SEGMENT_LIMIT = 128;

  localparam int TAIL_CYCLES = 8;        // allow slack for the skid
  localparam int RUN_LIMIT_NS = 5_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  can_sfb_in_if  in_ch ();
  can_sfb_out_if out_ch ();

  can_segmented_frame_builder_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor state: a private copy of the framer's message state.
  // ---------------------------------------------------------------------------
  logic        ext_mode;
  logic        msg_open;
  logic        drop_rest;    // rejected message: swallow the remaining bytes
  logic        idx_mode;
  logic [9:0]  taken;
  logic [9:0]  msg_len;
  logic [6:0]  seg_no;
  logic [2:0]  fill;
  logic [55:0] chunk;
  logic [15:0] msg_id;
  logic [7:0]  idx_byte;

  item_t   bytes_pending[$];   // byte beats not yet handed to the driver
  result_t frames_due[$];      // predicted frames, oldest first

  int send_idle;               // percent of cycles the sender holds off
  int recv_idle;               // percent of cycles the receiver stalls
  logic in_fire;               // byte beat accepted at the last rising edge

  int n_queued;
  int n_taken;
  int n_messages;
  int n_frames;
  int n_rejects;
  int n_bad;

  // Works out the frame (if any) that one accepted byte beat produces.
  task automatic predict_frame(input item_t b);
    result_t f;
    int      cap;
    logic    is_last;
    f = '0;
    if (!msg_open) begin
      // first beat of a message: latch the per-message fields
      msg_len   = b.message_length;
      msg_id    = b.frame_id;
      idx_mode  = b.index_en;
      idx_byte  = b.entry_index;
      taken     = '0;
      seg_no    = '0;
      fill      = '0;
      chunk     = '0;
      drop_rest = 1'b0;
      cap = idx_mode ? PAYLOAD_IDX : PAYLOAD_PLAIN;
      f.out_frame_id  = msg_id;
      f.extended_flag = ext_mode;
      if (msg_len == 10'd0) begin
        // empty message: header (last bit set) plus index byte when enabled
        f.frame_length = idx_mode ? 4'd2 : 4'd1;
        f.frame_data   = {48'h0, idx_mode ? idx_byte : 8'h00, 1'b1, 7'h00};
        f.last_frame   = 1'b1;
        frames_due = {frames_due, f};
        return;
      end
      if (int'(msg_len) > cap * SEGMENT_LIMIT) begin
        // too many segments: one reject beat, then drop the rest of the message
        f.status = 1'b1;
        frames_due = {frames_due, f};
        taken = 10'd1;
        if (taken < msg_len) begin
          msg_open  = 1'b1;
          drop_rest = 1'b1;
        end
        return;
      end
      msg_open = 1'b1;
    end

    if (drop_rest) begin
      taken = taken + 10'd1;
      if (taken >= msg_len) begin
        msg_open  = 1'b0;
        drop_rest = 1'b0;
      end
      return;
    end

    cap = idx_mode ? PAYLOAD_IDX : PAYLOAD_PLAIN;
    chunk[fill * 8 +: 8] = b.payload_byte;
    fill  = fill + 3'd1;
    taken = taken + 10'd1;
    is_last = (taken >= msg_len);
    if (!is_last && fill < cap) return;

    f.out_frame_id  = msg_id;
    f.extended_flag = ext_mode;
    f.last_frame    = is_last;
    if (idx_mode) begin
      f.frame_length = 4'd2 + 4'(fill);
      f.frame_data   = 64'({chunk, idx_byte, is_last, seg_no});
    end else begin
      f.frame_length = 4'd1 + 4'(fill);
      f.frame_data   = {chunk, is_last, seg_no};
    end
    frames_due = {frames_due, f};

    seg_no = seg_no + 7'd1;
    fill   = '0;
    chunk  = '0;
    if (is_last) begin
      msg_open = 1'b0;
      taken    = '0;
      seg_no   = '0;
    end
  endtask

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      n_bad++;
    end
  endtask

  // Compares the frame beat on the output channel with the oldest prediction.
  task automatic check_frame();
    result_t got;
    result_t want;
    got.out_frame_id  = out_ch.out_frame_id;
    got.frame_length  = out_ch.frame_length;
    got.frame_data    = out_ch.frame_data;
    got.extended_flag = out_ch.extended_flag;
    got.last_frame    = out_ch.last_frame;
    got.status        = out_ch.status;
    if (frames_due.size() == 0) begin
      $display("%0t: frame beat with none expected: expected nothing, actual %h",
               $time, got);
      n_bad++;
      return;
    end
    want = frames_due.pop_front();
    report_field("out_frame_id",  64'(want.out_frame_id),  64'(got.out_frame_id));
    report_field("frame_length",  64'(want.frame_length),  64'(got.frame_length));
    report_field("frame_data",    want.frame_data,         got.frame_data);
    report_field("extended_flag", 64'(want.extended_flag), 64'(got.extended_flag));
    report_field("last_frame",    64'(want.last_frame),    64'(got.last_frame));
    report_field("status",        64'(want.status),        64'(got.status));
    if (want.status) n_rejects++;
    else n_frames++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge. Output checked before the
  // input beat is predicted; a beat taken at this edge cannot show up before
  // the next one anyway.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_channels
    item_t b;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_frame();
      in_fire <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        b.payload_byte   = in_ch.payload_byte;
        b.message_length = in_ch.message_length;
        b.frame_id       = in_ch.frame_id;
        b.index_en       = in_ch.index_en;
        b.entry_index    = in_ch.entry_index;
        n_taken++;
        predict_frame(b);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte driver: falling edge. A held beat stays put until the monitor saw it
  // accepted; valid gets at most one assignment per edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_bytes
    item_t nb;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (bytes_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
        nb = bytes_pending.pop_front();
        in_ch.valid          <= 1'b1;
        in_ch.payload_byte   <= nb.payload_byte;
        in_ch.message_length <= nb.message_length;
        in_ch.frame_id       <= nb.frame_id;
        in_ch.index_en       <= nb.index_en;
        in_ch.entry_index    <= nb.entry_index;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_ch.ready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic item_t random_byte_beat();
    item_t r;
    r.payload_byte   = 8'($urandom);
    r.message_length = 10'($urandom);
    r.frame_id       = 16'($urandom);
    r.index_en       = 1'($urandom);
    r.entry_index    = 8'($urandom);
    return r;
  endfunction

  // Queues one message. Only the first beat carries the real header fields; the
  // rest carry random junk there, which the framer must ignore.
  // A negative fixed_pay means random payload bytes.
  task automatic queue_message(input int len, input logic [15:0] id, input logic wi,
                               input logic [7:0] ix, input int fixed_pay);
    item_t b;
    int    n;
    n = (len == 0) ? 1 : len;
    for (int k = 0; k < n; k++) begin
      b = random_byte_beat();
      if (fixed_pay >= 0) b.payload_byte = 8'(fixed_pay);
      if (k == 0) begin
        b.message_length = 10'(len);
        b.frame_id       = id;
        b.index_en       = wi;
        b.entry_index    = ix;
      end
      bytes_pending = {bytes_pending, b};
      n_queued++;
    end
    n_messages++;
  endtask

  // Holds the sender off until every byte is in and every frame is out, then
  // lets the tail of the pipeline settle.
  task automatic wait_drained();
    while (n_taken != n_queued || frames_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access; the write lands when pready is seen.
  task automatic set_register(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    wait_drained();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_EXT_MODE) ext_mode = data[0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random legal messages, mostly short so that segment boundaries get hit
  // often. Every byte counts toward the budget; the last length is trimmed.
  task automatic random_messages(input int budget);
    int   used;
    int   len;
    int   roll;
    logic wi;
    used = 0;
    while (used < budget) begin
      wi   = 1'($urandom);
      roll = $urandom_range(99);
      if (roll < 10)      len = 0;
      else if (roll < 75) len = $urandom_range(14, 1);
      else if (roll < 92) len = $urandom_range(40, 15);
      else                len = $urandom_range(120, 41);
      if (len > budget - used) len = budget - used;
      queue_message(len, 16'($urandom), wi, 8'($urandom), -1);
      used += (len == 0) ? 1 : len;
      // occasional full stop of the sender until the frame queue empties
      if ($urandom_range(5) == 0) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    item_t ob;
    in_ch.valid          = 1'b0;
    in_ch.payload_byte   = '0;
    in_ch.message_length = '0;
    in_ch.frame_id       = '0;
    in_ch.index_en       = 1'b0;
    in_ch.entry_index    = '0;
    out_ch.ready         = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    // predictor mirrors the reset state; extended mode comes up set
    ext_mode  = 1'b1;
    msg_open  = 1'b0;
    drop_rest = 1'b0;
    idx_mode  = 1'b0;
    taken     = '0;
    msg_len   = '0;
    seg_no    = '0;
    fill      = '0;
    chunk     = '0;
    msg_id    = '0;
    idx_byte  = '0;
    n_queued = 0; n_taken = 0; n_messages = 0;
    n_frames = 0; n_rejects = 0; n_bad = 0;

    send_idle = 11;
    recv_idle = 86;

    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: empty messages both ways, single byte, exactly one full
    // frame in each mode, and a frame that spills into a short second one.
    queue_message(0, 16'h0000, 1'b0, 8'h00, -1);
    queue_message(0, 16'hFFFF, 1'b1, 8'hFF, -1);
    queue_message(1, 16'hFFFF, 1'b0, 8'h00, 255);
    queue_message(7, 16'h0000, 1'b0, 8'hFF, 0);
    queue_message(6, 16'hA55A, 1'b1, 8'hA5, -1);
    queue_message(8, 16'h5AA5, 1'b1, 8'h5A, -1);

    // Phase A: slow receiver, extended mode cleared.
    set_register(ADDR_EXT_MODE, 32'h0);
    random_messages(140);

    // Phase B: slow sender. Write to the unmapped slot must change nothing.
    set_register(ADDR_SPARE, 32'hFFFF_FFFF);
    send_idle = 86;
    recv_idle = 11;
    random_messages(70);
    set_register(ADDR_EXT_MODE, 32'hFFFF_FFFF);
    random_messages(70);

    // Phase C: no idling, extended mode set and then cleared.
    set_register(ADDR_EXT_MODE, 32'h1);
    send_idle = 0;
    recv_idle = 0;
    random_messages(70);
    set_register(ADDR_EXT_MODE, 32'h0);
    random_messages(70);

    // One past the index-mode limit: a reject beat, then five more of its bytes,
    // which are swallowed while the message stays open.
    for (int k = 0; k < 6; k++) begin
      ob = random_byte_beat();
      if (k == 0) begin
        ob.message_length = 10'(PAYLOAD_IDX * SEGMENT_LIMIT + 1);
        ob.index_en       = 1'b1;
      end
      bytes_pending = {bytes_pending, ob};
      n_queued++;
    end
    n_messages++;

    wait_drained();
    $display("Run covered %0d messages in %0d byte beats: %0d frames, %0d rejects checked.",
             n_messages, n_taken, n_frames, n_rejects);
    $display("Extended mode 0 and 1, empty/boundary/oversize messages, both stall ratios.");
    if (n_bad == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop if the handshakes ever hang.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout: %0d of %0d byte beats taken, %0d frames outstanding.",
             n_taken, n_queued, frames_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== can_segmented_frame_builder_top.f =====
+incdir+design
design/can_sfb_pkg.sv
design/can_sfb_in_if.sv
design/can_sfb_out_if.sv
design/can_sfb_core.sv
design/can_segmented_frame_builder_top.sv
test/can_segmented_frame_builder_top_test.sv
